@@ rtl/core/gbti_pkg.sv @@
package gbti_pkg;

  typedef struct packed {
    logic               sample_fresh;
    logic               payload_ok;
    logic [31:0]        sequence_req;
    logic signed [31:0] yaw_rate;
    logic [47:0]        timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               delta_valid;
    logic signed [31:0] dt_us;
    logic signed [31:0] rate;
    logic signed [47:0] delta_angle;
  } out_item_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NODATA = 2'd1;
  localparam logic [1:0] ST_FAULT  = 2'd2;

  localparam logic CFG_AVG_LEN = 1'b0;
  localparam logic CFG_MAX_GAP = 1'b1;

  localparam logic [15:0] AVG_LEN_RST = 16'd200;
  localparam logic [15:0] MAX_GAP_RST = 16'd250;

  localparam int TIMESTAMP_BITS_DEF = 48;
  localparam int SEQUENCE_BITS_DEF  = 32;

  localparam logic [25:0] US_PER_MS = 26'd1000;
  localparam logic [63:0] ROUND_HALF = 64'd1000000;
  localparam logic [20:0] ANGLE_DEN  = 21'd2000000;

endpackage

@@ rtl/core/gyro_bias_trapezoid_integrator.sv @@
// Sequence: no-data, fault, calibration and seeding items go from S_EVAL to S_OUT;
// the item that closes calibration passes S_DIV (64-step divide) before S_OUT;
// an integrating item passes S_MUL (32-step serial multiply) and S_DIV (64-step divide).
// One item at a time: the next transfer is taken the cycle after the result is loaded,
// so the input stays stalled until a result is loaded, longer while the output is stalled.
// Reset (async, active low): averaging length 200, gap limit 250 ms, calibration
// restarted, no previous sample held, output empty.
module gyro_bias_trapezoid_integrator #(
  parameter int TIMESTAMP_BITS = gbti_pkg::TIMESTAMP_BITS_DEF,
  parameter int SEQUENCE_BITS  = gbti_pkg::SEQUENCE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gbti_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gbti_pkg::out_item_t out_data_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;

  logic [15:0] avg_len_q, max_gap_q;
  logic [SEQUENCE_BITS-1:0]  last_seq_q, last_seq_d;
  logic calibrated_q, calibrated_d;
  logic [15:0] cal_count_q, cal_count_d;
  logic signed [47:0] cal_sum_q, cal_sum_d;
  logic signed [31:0] bias_q, bias_d;
  logic have_prev_q, have_prev_d;
  logic signed [31:0] prev_rate_q, prev_rate_d;
  logic [TIMESTAMP_BITS-1:0] prev_time_q, prev_time_d;

  gbti_pkg::in_item_t  it_q, it_d;
  gbti_pkg::out_item_t res_q, res_d, out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic [63:0] mc_q, mc_d, acc_q, acc_d, dv_q, dv_d;
  logic [31:0] mp_q, mp_d;
  logic [20:0] rem_q, rem_d;
  logic [20:0] den_q, den_d;
  logic neg_q, neg_d, op_bias_q, op_bias_d;

  logic [SEQUENCE_BITS-1:0]  seq;
  logic [TIMESTAMP_BITS-1:0] now, d_fwd, d_back;
  logic [25:0] gap_us;
  logic signed [47:0] sum_n;
  logic [15:0] cnt_n;
  logic signed [32:0] diff, rsum;
  logic signed [31:0] rate, dt;
  logic [32:0] mag_sum;
  logic [31:0] mag_dt;
  logic [21:0] sh;
  logic qbit;
  logic [63:0] q;
  logic accept, load_out;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign load_out   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign seq    = SEQUENCE_BITS'(it_q.sequence_req);
  assign now    = TIMESTAMP_BITS'(it_q.timestamp_us);
  assign gap_us = 26'(max_gap_q) * gbti_pkg::US_PER_MS;
  assign sum_n  = cal_sum_q + 48'(it_q.yaw_rate);
  assign cnt_n  = cal_count_q + 16'd1;
  assign diff   = 33'(it_q.yaw_rate) - 33'(bias_q);
  assign rate   = (diff[32] != diff[31]) ? {diff[32], {31{~diff[32]}}} : diff[31:0];
  assign rsum   = 33'(prev_rate_q) + 33'(rate);
  assign d_fwd  = now - prev_time_q;
  assign d_back = prev_time_q - now;
  assign dt     = (now >= prev_time_q) ? d_fwd[31:0]
                : (d_back > TIMESTAMP_BITS'(64'h8000_0000)) ? 32'sh8000_0000
                : -d_back[31:0];
  assign mag_sum = rsum[32] ? -rsum : rsum;
  assign mag_dt  = dt[31] ? -dt : dt;
  assign sh      = {rem_q, dv_q[63]};
  assign qbit    = (sh >= {1'b0, den_q});
  assign q       = {dv_q[62:0], qbit};

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    last_seq_d = last_seq_q;
    calibrated_d = calibrated_q;
    cal_count_d = cal_count_q;
    cal_sum_d = cal_sum_q;
    bias_d = bias_q;
    have_prev_d = have_prev_q;
    prev_rate_d = prev_rate_q;
    prev_time_d = prev_time_q;
    it_d = it_q;
    res_d = res_q;
    out_d = out_q;
    out_valid_d = out_valid_q;
    mc_d = mc_q;
    mp_d = mp_q;
    acc_d = acc_q;
    dv_d = dv_q;
    rem_d = rem_q;
    den_d = den_q;
    neg_d = neg_q;
    op_bias_d = op_bias_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          it_d = in_data_i;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        res_d = '0;
        res_d.status = gbti_pkg::ST_OK;
        state_d = S_OUT;
        if (!it_q.sample_fresh || seq == last_seq_q) begin
          res_d.status = gbti_pkg::ST_NODATA;
        end else if (!it_q.payload_ok) begin
          res_d.status = gbti_pkg::ST_FAULT;
        end else begin
          last_seq_d = seq;
          if (!calibrated_q) begin
            cal_sum_d = sum_n;
            cal_count_d = cnt_n;
            if (cnt_n >= avg_len_q && cnt_n != 16'd0) begin
              op_bias_d = 1'b1;
              neg_d = sum_n[47];
              dv_d = 64'(sum_n[47] ? -sum_n : sum_n);
              rem_d = '0;
              den_d = 21'(cnt_n);
              cnt_d = 6'd63;
              state_d = S_DIV;
            end
          end else if (!have_prev_q || (now >= prev_time_q &&
                       d_fwd > TIMESTAMP_BITS'(gap_us))) begin
            have_prev_d = 1'b1;
            prev_rate_d = rate;
            prev_time_d = now;
          end else begin
            prev_rate_d = rate;
            prev_time_d = now;
            res_d.delta_valid = 1'b1;
            res_d.dt_us = dt;
            res_d.rate = rate;
            op_bias_d = 1'b0;
            neg_d = rsum[32] ^ dt[31];
            mc_d = 64'(mag_sum);
            mp_d = mag_dt;
            acc_d = gbti_pkg::ROUND_HALF;
            cnt_d = 6'd31;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (mp_q[0]) begin
          acc_d = acc_q + mc_q;
        end
        mc_d = {mc_q[62:0], 1'b0};
        mp_d = {1'b0, mp_q[31:1]};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          dv_d = mp_q[0] ? acc_q + mc_q : acc_q;
          rem_d = '0;
          den_d = gbti_pkg::ANGLE_DEN;
          cnt_d = 6'd63;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = 21'(qbit ? sh - {1'b0, den_q} : sh);
        dv_d = q;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          if (op_bias_q) begin
            bias_d = neg_q ? -q[31:0] : q[31:0];
            calibrated_d = 1'b1;
          end else begin
            res_d.delta_angle = neg_q ? -q[47:0] : q[47:0];
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (load_out) begin
          out_d = res_q;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i && cfg_idx_i == gbti_pkg::CFG_AVG_LEN) begin
      calibrated_d = (cfg_wdata_i == 16'd0);
      cal_count_d = '0;
      cal_sum_d = '0;
      bias_d = '0;
      have_prev_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      avg_len_q <= gbti_pkg::AVG_LEN_RST;
      max_gap_q <= gbti_pkg::MAX_GAP_RST;
      last_seq_q <= '0;
      calibrated_q <= (gbti_pkg::AVG_LEN_RST == 16'd0);
      cal_count_q <= '0;
      cal_sum_q <= '0;
      bias_q <= '0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
      op_bias_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      if (cfg_we_i && cfg_idx_i == gbti_pkg::CFG_AVG_LEN) begin
        avg_len_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == gbti_pkg::CFG_MAX_GAP) begin
        max_gap_q <= cfg_wdata_i;
      end
      last_seq_q <= last_seq_d;
      calibrated_q <= calibrated_d;
      cal_count_q <= cal_count_d;
      cal_sum_q <= cal_sum_d;
      bias_q <= bias_d;
      have_prev_q <= have_prev_d;
      out_valid_q <= out_valid_d;
      op_bias_q <= op_bias_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_rate_q <= prev_rate_d;
    prev_time_q <= prev_time_d;
    it_q <= it_d;
    res_q <= res_d;
    out_q <= out_d;
    mc_q <= mc_d;
    mp_q <= mp_d;
    acc_q <= acc_d;
    dv_q <= dv_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EVAL) else $error("transfer not evaluated");

  a_seed_after_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !calibrated_q |-> !have_prev_q) else $error("seeded before calibration");

  a_delta_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.delta_valid |-> out_q.status == gbti_pkg::ST_OK)
    else $error("delta with bad status");

endmodule
